// ----- rtl/mtep_pkg.sv -----
// ----------------------------------------------------------------------------
// MIDI track event parser package
// Shared types and constants: parse phases, result kinds, status and meta
// codes, and the event record that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package mtep_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;

	typedef enum logic [3:0] {
		PH_DELTA     = 4'd0,
		PH_STATUS    = 4'd1,
		PH_DATA1     = 4'd2,
		PH_DATA2     = 4'd3,
		PH_DATA_ONE  = 4'd4,
		PH_META_TYPE = 4'd5,
		PH_META_LEN  = 4'd6,
		PH_TEMPO     = 4'd7,
		PH_SKIP      = 4'd8,
		PH_SYSEX_LEN = 4'd9
	} phase_t;

	typedef enum logic [2:0] {
		KIND_NOTE_ON  = 3'd0,
		KIND_NOTE_OFF = 3'd1,
		KIND_CHAN3    = 3'd2,
		KIND_CHAN2    = 3'd3,
		KIND_TEMPO    = 3'd4,
		KIND_END      = 3'd5,
		KIND_TRUNC    = 3'd6
	} kind_t;

	// Upper nibble of a channel status byte.
	localparam logic [3:0] CMD_NOTE_OFF = 4'h8;
	localparam logic [3:0] CMD_NOTE_ON  = 4'h9;
	localparam logic [3:0] CMD_PROGRAM  = 4'hC;
	localparam logic [3:0] CMD_PRESSURE = 4'hD;

	// System status bytes.
	localparam logic [7:0] ST_SYSEX     = 8'hF0;
	localparam logic [7:0] ST_SONG_POS  = 8'hF2;
	localparam logic [7:0] ST_SONG_SEL  = 8'hF3;
	localparam logic [7:0] ST_SYSEX_ESC = 8'hF7;
	localparam logic [7:0] ST_META      = 8'hFF;

	// Meta event types.
	localparam logic [7:0] META_SEQ_NUM = 8'h00;
	localparam logic [7:0] META_CHAN    = 8'h20;
	localparam logic [7:0] META_PORT    = 8'h21;
	localparam logic [7:0] META_EOT     = 8'h2F;
	localparam logic [7:0] META_TEMPO   = 8'h51;
	localparam logic [7:0] META_SMPTE   = 8'h54;
	localparam logic [7:0] META_TIMESIG = 8'h58;
	localparam logic [7:0] META_KEYSIG  = 8'h59;

	// Everything one input byte produces: an optional event and an optional
	// truncated-end marker that follows it.
	typedef struct packed {
		logic        has_prim;
		logic        has_trunc;
		kind_t       kind;
		logic [7:0]  status;
		logic [6:0]  first_data;
		logic [6:0]  second_data;
		logic [19:0] track_channel;
		logic [63:0] tick;
		logic [23:0] tempo;
		logic [31:0] notes;
	} rec_t;

endpackage

// ----- rtl/mtep_if.sv -----
// ----------------------------------------------------------------------------
// MIDI track event parser channels
// Valid/ready channels for the incoming track bytes and the outgoing events.
// ----------------------------------------------------------------------------
interface mtep_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       track_start;
	logic       track_last;

	modport source (output valid, data_byte, track_start, track_last, input ready);
	modport sink (input valid, data_byte, track_start, track_last, output ready);
endinterface

interface mtep_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [7:0]  status_out;
	logic [6:0]  first_data;
	logic [6:0]  second_data;
	logic [19:0] track_channel;
	logic [63:0] event_tick;
	logic [23:0] tempo_value;
	logic [31:0] notes_seen;
	logic        last_of_run;

	modport source (output valid, kind, status_out, first_data, second_data,
		track_channel, event_tick, tempo_value, notes_seen, last_of_run,
		input ready);
	modport sink (input valid, kind, status_out, first_data, second_data,
		track_channel, event_tick, tempo_value, notes_seen, last_of_run,
		output ready);
endinterface

// ----- rtl/mtep_front.sv -----
// ----------------------------------------------------------------------------
// MIDI track event parser front end
// Byte-level parse state machine: delta times, running status, channel
// messages, meta and sysex handling. Builds one event record per byte.
// ----------------------------------------------------------------------------
module mtep_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [15:0]          cfg_wdata,
	input  logic                 accept,
	input  logic [7:0]           data_byte,
	input  logic                 track_start,
	input  logic                 track_last,
	output logic                 push,
	output mtep_pkg::rec_t       rec
);
	import mtep_pkg::*;

	phase_t      phase_q, cur_phase, nxt_phase;
	logic [7:0]  rstat_q, cur_rstat, nxt_rstat;
	logic [31:0] vacc_q, cur_vacc, nxt_vacc;
	logic [63:0] tick_q, cur_tick, nxt_tick;
	logic [31:0] skip_q, cur_skip, nxt_skip;
	logic [7:0]  meta_q, cur_meta, nxt_meta;
	logic [7:0]  held_q, cur_held, nxt_held;
	logic [23:0] tempo_q, cur_tempo, nxt_tempo;
	logic        done_q, cur_done, nxt_done;
	logic [31:0] notes_q, cur_notes, nxt_notes;
	logic [15:0] track_index_q;

	logic [31:0] vl_val;
	logic        vl_end;
	logic [3:0]  cmd;
	logic [3:0]  ch;
	logic [31:0] tick_add;
	logic        do_chan;
	logic        do_skip;
	logic [31:0] skip_val;
	logic        one_data;

	always_comb begin
		cur_phase = track_start ? PH_DELTA : phase_q;
		cur_rstat = track_start ? '0 : rstat_q;
		cur_vacc  = track_start ? '0 : vacc_q;
		cur_tick  = track_start ? '0 : tick_q;
		cur_skip  = track_start ? '0 : skip_q;
		cur_meta  = track_start ? '0 : meta_q;
		cur_held  = track_start ? '0 : held_q;
		cur_tempo = track_start ? '0 : tempo_q;
		cur_done  = track_start ? 1'b0 : done_q;
		cur_notes = track_start ? '0 : notes_q;

		nxt_phase = cur_phase;
		nxt_rstat = cur_rstat;
		nxt_vacc  = cur_vacc;
		nxt_skip  = cur_skip;
		nxt_meta  = cur_meta;
		nxt_held  = cur_held;
		nxt_tempo = cur_tempo;
		nxt_done  = cur_done;
		nxt_notes = cur_notes;

		vl_val   = {cur_vacc[24:0], data_byte[6:0]};
		vl_end   = !data_byte[7];
		cmd      = cur_rstat[7:4];
		ch       = cur_rstat[3:0];
		one_data = (cmd == CMD_PROGRAM) || (cmd == CMD_PRESSURE);
		tick_add = '0;
		do_chan  = 1'b0;
		do_skip  = 1'b0;
		skip_val = '0;

		rec               = '0;
		rec.kind          = KIND_NOTE_ON;

		if (!cur_done) begin
			unique case (cur_phase)
				PH_DELTA: begin
					if (vl_end) begin
						tick_add  = vl_val;
						nxt_vacc  = '0;
						nxt_phase = PH_STATUS;
					end else begin
						nxt_vacc = vl_val;
					end
				end
				PH_STATUS: begin
					if (!data_byte[7]) begin
						// A data byte with no running status counts as a short delta.
						if (!cur_rstat[7]) begin
							tick_add = {24'd0, data_byte};
						end else begin
							do_chan = 1'b1;
						end
					end else if (data_byte >= ST_SYSEX) begin
						nxt_rstat = '0;
						if (data_byte == ST_META) begin
							nxt_phase = PH_META_TYPE;
						end else if (data_byte == ST_SYSEX || data_byte == ST_SYSEX_ESC) begin
							nxt_vacc  = '0;
							nxt_phase = PH_SYSEX_LEN;
						end else if (data_byte == ST_SONG_POS) begin
							do_skip  = 1'b1;
							skip_val = 32'd2;
						end else if (data_byte == ST_SONG_SEL) begin
							do_skip  = 1'b1;
							skip_val = 32'd1;
						end else begin
							nxt_phase = PH_DELTA;
						end
					end else begin
						nxt_rstat = data_byte;
						nxt_phase = ((data_byte[7:4] == CMD_PROGRAM)
							|| (data_byte[7:4] == CMD_PRESSURE)) ? PH_DATA_ONE : PH_DATA1;
					end
				end
				PH_DATA1, PH_DATA_ONE: begin
					do_chan = 1'b1;
				end
				PH_DATA2: begin
					rec.has_prim    = 1'b1;
					rec.first_data  = cur_held[6:0];
					rec.second_data = data_byte[6:0];
					rec.status      = cur_rstat;
					if (cmd == CMD_NOTE_OFF || (cmd == CMD_NOTE_ON && data_byte == 8'd0)) begin
						rec.kind          = KIND_NOTE_OFF;
						rec.status        = {CMD_NOTE_OFF, ch};
						rec.track_channel = {track_index_q, ch};
					end else if (cmd == CMD_NOTE_ON) begin
						rec.kind          = KIND_NOTE_ON;
						rec.track_channel = {track_index_q, ch};
						nxt_notes         = cur_notes + 32'd1;
					end else begin
						rec.kind = KIND_CHAN3;
					end
					nxt_phase = PH_DELTA;
				end
				PH_META_TYPE: begin
					nxt_meta  = data_byte;
					nxt_vacc  = '0;
					nxt_phase = PH_META_LEN;
				end
				PH_META_LEN: begin
					if (!vl_end) begin
						nxt_vacc = vl_val;
					end else begin
						nxt_vacc = '0;
						unique case (cur_meta) inside
							META_EOT: begin
								rec.has_prim   = 1'b1;
								rec.kind       = KIND_END;
								rec.status     = ST_META;
								rec.first_data = META_EOT[6:0];
								nxt_done       = 1'b1;
								nxt_phase      = PH_DELTA;
							end
							META_TEMPO: begin
								nxt_tempo = '0;
								nxt_skip  = 32'd3;
								nxt_phase = PH_TEMPO;
							end
							META_SEQ_NUM, META_KEYSIG: begin
								do_skip  = 1'b1;
								skip_val = 32'd2;
							end
							META_CHAN, META_PORT: begin
								do_skip  = 1'b1;
								skip_val = 32'd1;
							end
							META_SMPTE: begin
								do_skip  = 1'b1;
								skip_val = 32'd5;
							end
							META_TIMESIG: begin
								do_skip  = 1'b1;
								skip_val = 32'd4;
							end
							default: begin
								do_skip  = 1'b1;
								skip_val = vl_val;
							end
						endcase
					end
				end
				PH_TEMPO: begin
					nxt_tempo = {cur_tempo[15:0], data_byte};
					nxt_skip  = cur_skip - 32'd1;
					if (cur_skip == 32'd1) begin
						rec.has_prim   = 1'b1;
						rec.kind       = KIND_TEMPO;
						rec.status     = ST_META;
						rec.first_data = META_TEMPO[6:0];
						rec.tempo      = {cur_tempo[15:0], data_byte};
						nxt_phase      = PH_DELTA;
					end
				end
				PH_SKIP: begin
					nxt_skip = cur_skip - 32'd1;
					if (cur_skip == 32'd1) begin
						nxt_phase = PH_DELTA;
					end
				end
				PH_SYSEX_LEN: begin
					if (vl_end) begin
						nxt_vacc = '0;
						do_skip  = 1'b1;
						skip_val = vl_val;
					end else begin
						nxt_vacc = vl_val;
					end
				end
				default: begin
					nxt_phase = PH_DELTA;
				end
			endcase
		end

		// First or only data byte of a channel message.
		if (do_chan) begin
			if (one_data) begin
				rec.has_prim   = 1'b1;
				rec.kind       = KIND_CHAN2;
				rec.status     = cur_rstat;
				rec.first_data = data_byte[6:0];
				nxt_phase      = PH_DELTA;
			end else begin
				nxt_held  = data_byte;
				nxt_phase = PH_DATA2;
			end
		end

		if (do_skip) begin
			nxt_skip  = skip_val;
			nxt_phase = (skip_val != 32'd0) ? PH_SKIP : PH_DELTA;
		end

		nxt_tick = cur_tick + {32'd0, tick_add};

		if (track_last && !nxt_done) begin
			rec.has_trunc = 1'b1;
			nxt_done      = 1'b1;
		end

		rec.tick  = nxt_tick;
		rec.notes = nxt_notes;
		push      = accept && (rec.has_prim || rec.has_trunc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_DELTA;
			rstat_q       <= '0;
			vacc_q        <= '0;
			tick_q        <= '0;
			skip_q        <= '0;
			meta_q        <= '0;
			held_q        <= '0;
			tempo_q       <= '0;
			done_q        <= 1'b0;
			notes_q       <= '0;
			track_index_q <= '0;
		end else begin
			if (cfg_wen) begin
				track_index_q <= cfg_wdata;
			end
			if (accept) begin
				phase_q <= nxt_phase;
				rstat_q <= nxt_rstat;
				vacc_q  <= nxt_vacc;
				tick_q  <= nxt_tick;
				skip_q  <= nxt_skip;
				meta_q  <= nxt_meta;
				held_q  <= nxt_held;
				tempo_q <= nxt_tempo;
				done_q  <= nxt_done;
				notes_q <= nxt_notes;
			end
		end
	end

	// Once a track has ended, only a new track start may reopen it.
	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && !(accept && track_start) |=> done_q)
		else $error("track end flag dropped without a track start");

	// A finished track produces no further results until restarted.
	a_no_result_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && !track_start |-> !push)
		else $error("result produced after end of track");

	// Note count only moves by one, and only on a note on result.
	a_note_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !track_start && (nxt_notes != notes_q) |->
		(rec.has_prim && rec.kind == KIND_NOTE_ON && nxt_notes == notes_q + 32'd1))
		else $error("note count changed without a note on");

endmodule

// ----- rtl/mtep_queue.sv -----
// ----------------------------------------------------------------------------
// MIDI track event parser record queue
// Small first-in first-out buffer of event records between front and back.
// ----------------------------------------------------------------------------
module mtep_queue #(
	parameter int unsigned DEPTH = mtep_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mtep_pkg::rec_t push_rec,
	input  logic           pop,
	output logic           not_empty,
	output logic           full,
	output mtep_pkg::rec_t head_rec
);
	import mtep_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	rec_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;

	assign not_empty = (count_q != '0);
	assign full      = (count_q == CNT_W'(DEPTH));
	assign head_rec  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> !full)
		else $error("record queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("record queue underflow");

endmodule

// ----- rtl/mtep_back.sv -----
// ----------------------------------------------------------------------------
// MIDI track event parser back end
// Unpacks each record into one or two events and holds them in the output
// register until the consumer takes them.
// ----------------------------------------------------------------------------
module mtep_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rec_valid,
	input  mtep_pkg::rec_t    rec,
	output logic              pop,
	mtep_out_if.source        events
);
	import mtep_pkg::*;

	logic        out_valid_q;
	logic        pend_q;
	kind_t       kind_q;
	logic [7:0]  status_q;
	logic [6:0]  d1_q;
	logic [6:0]  d2_q;
	logic [19:0] chan_q;
	logic [63:0] tick_q;
	logic [23:0] tempo_q;
	logic [31:0] notes_q;
	logic        last_q;

	logic slot_free;
	logic load_trunc;

	assign slot_free  = !out_valid_q || events.ready;
	assign load_trunc = slot_free && out_valid_q && pend_q;
	assign pop        = slot_free && !(out_valid_q && pend_q) && rec_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else if (slot_free) begin
			if (load_trunc) begin
				out_valid_q <= 1'b1;
				pend_q      <= 1'b0;
			end else begin
				out_valid_q <= rec_valid;
				pend_q      <= rec_valid && rec.has_prim && rec.has_trunc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_trunc || (pop && !rec.has_prim)) begin
			// Truncated marker: only tick and note count carry information.
			kind_q   <= KIND_TRUNC;
			status_q <= '0;
			d1_q     <= '0;
			d2_q     <= '0;
			chan_q   <= '0;
			tempo_q  <= '0;
			last_q   <= 1'b1;
		end else if (pop) begin
			kind_q   <= rec.kind;
			status_q <= rec.status;
			d1_q     <= rec.first_data;
			d2_q     <= rec.second_data;
			chan_q   <= rec.track_channel;
			tempo_q  <= rec.tempo;
			last_q   <= !rec.has_trunc;
		end
		if (pop) begin
			tick_q  <= rec.tick;
			notes_q <= rec.notes;
		end
	end

	assign events.valid         = out_valid_q;
	assign events.kind          = kind_q;
	assign events.status_out    = status_q;
	assign events.first_data    = d1_q;
	assign events.second_data   = d2_q;
	assign events.track_channel = chan_q;
	assign events.event_tick    = tick_q;
	assign events.tempo_value   = tempo_q;
	assign events.notes_seen    = notes_q;
	assign events.last_of_run   = last_q;

	// An event with a pending truncated marker is followed directly by it.
	a_trunc_follows: assert property (@(posedge clk) disable iff (!arst_n)
		events.valid && events.ready && pend_q |=>
		events.valid && events.kind == KIND_TRUNC && events.last_of_run)
		else $error("truncated marker did not follow its event");

	// A result that is not the last of its byte always has a follower pending.
	a_not_last_pending: assert property (@(posedge clk) disable iff (!arst_n)
		events.valid && !events.last_of_run |-> pend_q)
		else $error("non-final result without a pending follower");

endmodule

// ----- rtl/midi_track_event_parser.sv -----
// Data path: the record of a transferred byte enters the queue at the transfer edge and moves into
// the output register once the back end has a free output slot.
// Throughput: one byte per cycle while the queue has room; a byte that yields an event and a
// truncated marker gives two output transfers, the marker after the event.
// Reset (arst_n low, asynchronous) clears parse state, counters, track index, queue and output.
// ----------------------------------------------------------------------------
// MIDI track event parser
// Parses the bytes of one track chunk into timed note, channel, tempo and
// end-of-track events, with running status and a 64-bit running tick count.
// ----------------------------------------------------------------------------
module midi_track_event_parser #(
	parameter int unsigned QUEUE_DEPTH = mtep_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [15:0] cfg_wdata,
	mtep_in_if.sink     bytes,
	mtep_out_if.source  events
);
	import mtep_pkg::*;

	// The front end decodes one byte per transfer. Its state moves only on an
	// accepted byte, and it pushes a record into the queue when the byte
	// produced an event, a truncated marker, or both.
	logic accept;
	logic push;
	rec_t push_rec;

	// Queue status and head record seen by the back end.
	logic q_not_empty;
	logic q_full;
	logic q_pop;
	rec_t head_rec;

	// A byte is taken whenever the queue has room, regardless of whether the
	// output side is stalled; the queue absorbs short output stalls.
	assign bytes.ready = !q_full;
	assign accept      = bytes.valid && bytes.ready;

	mtep_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_wdata   (cfg_wdata),
		.accept      (accept),
		.data_byte   (bytes.data_byte),
		.track_start (bytes.track_start),
		.track_last  (bytes.track_last),
		.push        (push),
		.rec         (push_rec)
	);

	mtep_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_rec  (push_rec),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.full      (q_full),
		.head_rec  (head_rec)
	);

	// The back end turns each record into one or two output transfers, the
	// truncated marker always coming after the event of the same byte.
	mtep_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (q_not_empty),
		.rec       (head_rec),
		.pop       (q_pop),
		.events    (events)
	);

endmodule

// ----- tb/midi_track_event_parser_tb.sv -----
// ----------------------------------------------------------------------------
// MIDI track event parser testbench
// Streams track chunk bytes into the parser and checks every event against
// a cycle-free software copy of the parser. It starts with two short hand-built
// tracks and then sends randomly shaped tracks. Both channels idle and stall at
// random, and the track index register is rewritten between phases.
// ----------------------------------------------------------------------------
module midi_track_event_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mtep_pkg::*;

	// Run length and pacing.
	localparam int RANDOM_ITEMS = 850;
	localparam int CHUNK_ITEMS  = 120;
	// A byte's record passes through the queue into the output register, and
	// a truncated marker follows the event of the same byte there.
	// This pad covers bytes still in flight that produce no event at all.
	localparam int LATENCY_PAD  = 6;
	localparam int END_PAD      = 12;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int REPORT_LIMIT = 10;

	// Channel command nibbles and system codes that the package leaves out.
	localparam logic [3:0] CMD_POLY_PRESS  = 4'hA;
	localparam logic [3:0] CMD_CONTROL     = 4'hB;
	localparam logic [3:0] CMD_PITCH       = 4'hE;
	localparam logic [3:0] CMD_SYSTEM      = 4'hF;
	localparam logic [7:0] ST_QUARTER_FR   = 8'hF1;
	localparam logic [7:0] ST_UNDEF_FIRST  = 8'hF4;
	localparam logic [7:0] ST_UNDEF_LAST   = 8'hFE;

	// One byte of a track chunk with its framing flags.
	typedef struct packed {
		logic [7:0] data;
		logic       start;
		logic       last;
	} track_byte_t;

	// One event as the output channel carries it.
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  status;
		logic [6:0]  first_data;
		logic [6:0]  second_data;
		logic [19:0] track_channel;
		logic [63:0] tick;
		logic [23:0] tempo;
		logic [31:0] notes;
		logic        last;
	} midi_event_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wen;
	logic [15:0] cfg_wdata;

	mtep_in_if  byte_ch ();
	mtep_out_if event_ch ();

	midi_track_event_parser DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata),
		.bytes    (byte_ch),
		.events   (event_ch)
	);

	always #1 clk = ~clk;

	// Bytes waiting to be sent, and events the parser still owes us.
	track_byte_t queued_bytes[$];
	midi_event_t pending_events[$];

	// Bytes of the track under construction, and the running status the
	// generator believes is active so it can leave status bytes out.
	logic [7:0] track_buf[$];
	logic [7:0] gen_status;

	// When set, neither side inserts idle cycles.
	bit steady;

	int send_gap;
	int recv_stall;
	int mismatch_count = 0;
	int cycle_count = 0;
	midi_event_t seen_event;
	midi_event_t due_event;

	// ------------------------------------------------------------------
	// Parser state mirror. It is updated once per byte transfer, in the
	// same order the parser works through a byte.
	// ------------------------------------------------------------------
	logic [15:0] cur_track_index;
	phase_t      parse_state;
	logic [7:0]  run_status;
	logic [31:0] varlen_acc;
	logic [63:0] ticks;
	logic [31:0] skip_left;
	logic [7:0]  meta_type;
	logic [7:0]  held_byte;
	logic [23:0] tempo_acc;
	logic        track_closed;
	logic [31:0] note_on_total;

	// A new track clears everything except the track index register.
	function automatic void clear_track_state();
		parse_state = PH_DELTA;
		run_status = 8'h00;
		varlen_acc = '0;
		ticks = '0;
		skip_left = '0;
		meta_type = 8'h00;
		held_byte = 8'h00;
		tempo_acc = '0;
		track_closed = 1'b0;
		note_on_total = '0;
	endfunction

	// Appends one owed event at the tail of the expected list.
	function automatic void owe_event(input midi_event_t ev);
		pending_events.insert(pending_events.size(), ev);
	endfunction

	function automatic void add_event(input kind_t kind, input logic [7:0] status,
			input logic [6:0] d1, input logic [6:0] d2, input logic [19:0] chan,
			input logic [23:0] tempo);
		midi_event_t ev;
		ev.kind = kind;
		ev.status = status;
		ev.first_data = d1;
		ev.second_data = d2;
		ev.track_channel = chan;
		ev.tick = ticks;
		ev.tempo = tempo;
		ev.notes = note_on_total;
		ev.last = 1'b0;
		owe_event(ev);
	endfunction

	// Variable-length numbers shift seven bits at a time into 32 bits and
	// simply wrap when they run long. True once the final byte is in.
	function automatic bit shift_varlen(input logic [7:0] b);
		varlen_acc = {varlen_acc[24:0], b[6:0]};
		return !b[7];
	endfunction

	function automatic void start_skip(input logic [31:0] count);
		skip_left = count;
		if (count != 0) begin
			parse_state = PH_SKIP;
		end else begin
			parse_state = PH_DELTA;
		end
	endfunction

	// First data byte of a channel message: program change and channel
	// pressure finish here, everything else waits for a second byte.
	function automatic void take_channel_data(input logic [7:0] b);
		if (run_status[7:4] == CMD_PROGRAM || run_status[7:4] == CMD_PRESSURE) begin
			add_event(KIND_CHAN2, run_status, b[6:0], 7'h00, 20'h0, 24'h0);
			parse_state = PH_DELTA;
		end else begin
			held_byte = b;
			parse_state = PH_DATA2;
		end
	endfunction

	function automatic void parse_track_byte(input logic [7:0] b);
		logic [3:0]  cmd;
		logic [3:0]  chan;
		logic [19:0] track_chan;
		logic [31:0] len;
		cmd = run_status[7:4];
		chan = run_status[3:0];
		track_chan = {cur_track_index, chan};
		case (parse_state)
			PH_DELTA: begin
				if (shift_varlen(b)) begin
					ticks = ticks + {32'h0, varlen_acc};
					varlen_acc = '0;
					parse_state = PH_STATUS;
				end
			end
			PH_STATUS: begin
				if (!b[7]) begin
					// A data byte with no running status is a one-byte delta.
					if (!run_status[7]) begin
						ticks = ticks + {56'h0, b};
					end else begin
						take_channel_data(b);
					end
				end else if (b[7:4] == CMD_SYSTEM) begin
					run_status = 8'h00;
					if (b == ST_META) begin
						parse_state = PH_META_TYPE;
					end else if (b == ST_SYSEX || b == ST_SYSEX_ESC) begin
						varlen_acc = '0;
						parse_state = PH_SYSEX_LEN;
					end else if (b == ST_SONG_POS) begin
						start_skip(2);
					end else if (b == ST_SONG_SEL) begin
						start_skip(1);
					end else begin
						parse_state = PH_DELTA;
					end
				end else begin
					run_status = b;
					if (b[7:4] == CMD_PROGRAM || b[7:4] == CMD_PRESSURE) begin
						parse_state = PH_DATA_ONE;
					end else begin
						parse_state = PH_DATA1;
					end
				end
			end
			PH_DATA1, PH_DATA_ONE: begin
				take_channel_data(b);
			end
			PH_DATA2: begin
				if (cmd == CMD_NOTE_OFF) begin
					add_event(KIND_NOTE_OFF, {CMD_NOTE_OFF, chan}, held_byte[6:0], b[6:0],
						track_chan, 24'h0);
				end else if (cmd == CMD_NOTE_ON) begin
					// Velocity is tested on all eight bits, so 0x80 still counts.
					if (b != 8'h00) begin
						note_on_total = note_on_total + 1;
						add_event(KIND_NOTE_ON, run_status, held_byte[6:0], b[6:0],
							track_chan, 24'h0);
					end else begin
						add_event(KIND_NOTE_OFF, {CMD_NOTE_OFF, chan}, held_byte[6:0],
							7'h00, track_chan, 24'h0);
					end
				end else begin
					add_event(KIND_CHAN3, run_status, held_byte[6:0], b[6:0], 20'h0, 24'h0);
				end
				parse_state = PH_DELTA;
			end
			PH_META_TYPE: begin
				meta_type = b;
				varlen_acc = '0;
				parse_state = PH_META_LEN;
			end
			PH_META_LEN: begin
				if (shift_varlen(b)) begin
					len = varlen_acc;
					varlen_acc = '0;
					// Standard meta events take their fixed size whatever length
					// they state; only unknown types honor the length.
					case (meta_type)
						META_EOT: begin
							add_event(KIND_END, ST_META, META_EOT[6:0], 7'h00, 20'h0, 24'h0);
							track_closed = 1'b1;
							parse_state = PH_DELTA;
						end
						META_TEMPO: begin
							tempo_acc = '0;
							skip_left = 3;
							parse_state = PH_TEMPO;
						end
						META_SEQ_NUM, META_KEYSIG: start_skip(2);
						META_CHAN, META_PORT:      start_skip(1);
						META_SMPTE:                start_skip(5);
						META_TIMESIG:              start_skip(4);
						default:                   start_skip(len);
					endcase
				end
			end
			PH_TEMPO: begin
				tempo_acc = {tempo_acc[15:0], b};
				skip_left = skip_left - 1;
				if (skip_left == 0) begin
					add_event(KIND_TEMPO, ST_META, META_TEMPO[6:0], 7'h00, 20'h0, tempo_acc);
					parse_state = PH_DELTA;
				end
			end
			PH_SKIP: begin
				skip_left = skip_left - 1;
				if (skip_left == 0) begin
					parse_state = PH_DELTA;
				end
			end
			PH_SYSEX_LEN: begin
				if (shift_varlen(b)) begin
					len = varlen_acc;
					varlen_acc = '0;
					start_skip(len);
				end
			end
			default: begin
				parse_state = PH_DELTA;
			end
		endcase
	endfunction

	// Works out every event one transferred byte causes and queues them.
	// A track that ends without an end-of-track event gets a truncated
	// marker after whatever the last byte produced.
	function automatic void predict_track_byte(input track_byte_t item);
		int n_prior;
		midi_event_t tail;
		n_prior = pending_events.size();
		if (item.start) begin
			clear_track_state();
		end
		if (!track_closed) begin
			parse_track_byte(item.data);
		end
		if (item.last && !track_closed) begin
			add_event(KIND_TRUNC, 8'h00, 7'h00, 7'h00, 20'h0, 24'h0);
			track_closed = 1'b1;
		end
		if (pending_events.size() > n_prior) begin
			tail = pending_events.pop_back();
			tail.last = 1'b1;
			owe_event(tail);
		end
	endfunction

	// ------------------------------------------------------------------
	// Stimulus construction.
	// ------------------------------------------------------------------

	// Appends one byte to the track under construction.
	function automatic void add_track_byte(input logic [7:0] b);
		track_buf.insert(track_buf.size(), b);
	endfunction

	// Mostly short gaps, sometimes a long one, none at all in steady phases.
	function automatic int pick_idle();
		int roll;
		if (steady) begin
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 55) begin
			return 0;
		end
		if (roll < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(4, 24);
	endfunction

	// Data bytes occasionally carry bit 7, which the parser still takes as data.
	function automatic logic [7:0] rand_data();
		if ($urandom_range(0, 9) == 0) begin
			return 8'($urandom_range(128, 255));
		end
		return 8'($urandom_range(0, 127));
	endfunction

	function automatic void put_delta();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) begin
			add_track_byte(8'h00);
		end else if (roll < 85) begin
			add_track_byte(8'($urandom_range(1, 127)));
		end else if (roll < 97) begin
			add_track_byte(8'($urandom_range(129, 255)));
			add_track_byte(8'($urandom_range(0, 127)));
		end else begin
			// Overlong delta that may wrap the 32-bit accumulator.
			repeat ($urandom_range(3, 5)) add_track_byte(8'($urandom_range(128, 255)));
			add_track_byte(8'($urandom_range(0, 127)));
		end
	endfunction

	// Emits a status byte for the command, or leaves it out half the time
	// when running status already covers it.
	function automatic void put_status(input logic [3:0] cmd);
		logic [7:0] s;
		if (gen_status[7] && gen_status[7:4] == cmd && $urandom_range(0, 1) == 1) begin
			return;
		end
		s = {cmd, 4'($urandom_range(0, 15))};
		add_track_byte(s);
		gen_status = s;
	endfunction

	// Length field of a meta or sysex event, sometimes in padded two-byte form.
	function automatic int put_length();
		int len;
		len = $urandom_range(0, 8);
		if ($urandom_range(0, 4) == 0) begin
			add_track_byte(8'h80);
		end
		add_track_byte(8'(len));
		return len;
	endfunction

	function automatic void add_random_event();
		int roll;
		int len;
		logic [7:0] mtype;
		put_delta();
		roll = $urandom_range(0, 99);
		if (roll < 30) begin
			put_status(($urandom_range(0, 2) == 0) ? CMD_NOTE_OFF : CMD_NOTE_ON);
			add_track_byte(rand_data());
			add_track_byte(($urandom_range(0, 7) == 0) ? 8'h00 : rand_data());
		end else if (roll < 40) begin
			case ($urandom_range(0, 2))
				0:       put_status(CMD_POLY_PRESS);
				1:       put_status(CMD_CONTROL);
				default: put_status(CMD_PITCH);
			endcase
			add_track_byte(rand_data());
			add_track_byte(rand_data());
		end else if (roll < 48) begin
			put_status(($urandom_range(0, 1) == 0) ? CMD_PROGRAM : CMD_PRESSURE);
			add_track_byte(rand_data());
		end else if (roll < 56) begin
			// Tempo always takes three bytes, even when its length disagrees.
			gen_status = 8'h00;
			add_track_byte(ST_META);
			add_track_byte(META_TEMPO);
			add_track_byte(($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 6)) : 8'd3);
			repeat (3) add_track_byte(8'($urandom_range(0, 255)));
		end else if (roll < 64) begin
			gen_status = 8'h00;
			case ($urandom_range(0, 5))
				0: begin mtype = META_SEQ_NUM; len = 2; end
				1: begin mtype = META_CHAN;    len = 1; end
				2: begin mtype = META_PORT;    len = 1; end
				3: begin mtype = META_SMPTE;   len = 5; end
				4: begin mtype = META_TIMESIG; len = 4; end
				default: begin mtype = META_KEYSIG; len = 2; end
			endcase
			add_track_byte(ST_META);
			add_track_byte(mtype);
			add_track_byte(8'($urandom_range(0, 6)));
			repeat (len) add_track_byte(8'($urandom_range(0, 255)));
		end else if (roll < 72) begin
			gen_status = 8'h00;
			add_track_byte(ST_META);
			add_track_byte(8'($urandom_range(0, 255)));
			len = put_length();
			repeat (len) add_track_byte(8'($urandom_range(0, 255)));
		end else if (roll < 80) begin
			gen_status = 8'h00;
			add_track_byte(($urandom_range(0, 1) == 0) ? ST_SYSEX : ST_SYSEX_ESC);
			len = put_length();
			repeat (len) add_track_byte(8'($urandom_range(0, 255)));
		end else if (roll < 86) begin
			gen_status = 8'h00;
			if ($urandom_range(0, 1) == 0) begin
				add_track_byte(ST_SONG_POS);
				repeat (2) add_track_byte(rand_data());
			end else begin
				add_track_byte(ST_SONG_SEL);
				add_track_byte(rand_data());
			end
		end else if (roll < 90) begin
			gen_status = 8'h00;
			if ($urandom_range(0, 10) == 0) begin
				add_track_byte(ST_QUARTER_FR);
			end else begin
				add_track_byte(8'($urandom_range(ST_UNDEF_FIRST, ST_UNDEF_LAST)));
			end
		end else if (roll < 95) begin
			add_track_byte(8'($urandom_range(0, 127)));
		end else begin
			repeat ($urandom_range(1, 3)) add_track_byte(8'($urandom_range(0, 255)));
		end
	endfunction

	// Moves the track under construction into the send queue with its flags.
	function automatic void flush_track(input bit with_start, input bit with_last);
		track_byte_t item;
		foreach (track_buf[i]) begin
			item.data = track_buf[i];
			item.start = with_start && (i == 0);
			item.last = with_last && (i == track_buf.size() - 1);
			queued_bytes.insert(queued_bytes.size(), item);
		end
	endfunction

	// Builds and queues one random track. The return value leaves out the
	// bytes after end of track, which the parser only discards.
	function automatic int build_random_track();
		int counted;
		int end_roll;
		track_buf.delete();
		gen_status = 8'h00;
		if ($urandom_range(0, 29) == 0) begin
			// Single-byte track: start and last on the same byte.
			add_track_byte(8'($urandom_range(0, 255)));
			flush_track(1'b1, 1'b1);
			return 1;
		end
		repeat ($urandom_range(1, 10)) add_random_event();
		end_roll = $urandom_range(0, 9);
		if (end_roll < 7) begin
			put_delta();
			add_track_byte(ST_META);
			add_track_byte(META_EOT);
			add_track_byte(8'h00);
		end else if (end_roll == 9) begin
			// Chop the tail so the track stops in the middle of an event.
			repeat ($urandom_range(1, 3)) begin
				if (track_buf.size() > 1) begin
					void'(track_buf.pop_back());
				end
			end
		end
		counted = track_buf.size();
		if (end_roll < 7 && $urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 3)) add_track_byte(8'($urandom_range(0, 255)));
		end
		flush_track($urandom_range(0, 19) != 0, $urandom_range(0, 19) != 0);
		return counted;
	endfunction

	// Waits until every byte is sent and every owed event has arrived, then
	// lets the pipeline settle. Sampling at the falling edge keeps this clear
	// of the driver and monitor, which act on the rising edge.
	task automatic wait_drained(input int pad);
		@(negedge clk);
		while (queued_bytes.size() != 0 || byte_ch.valid || pending_events.size() != 0)
			@(negedge clk);
		repeat (pad) @(negedge clk);
	endtask

	// Register writes happen only while the parser is idle.
	task automatic write_track_index(input logic [15:0] value);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		cur_track_index = value;
		@(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Byte driver. A byte leaves the queue on the edge where its transfer
	// completes, and that is also when its events are predicted. A random
	// gap may follow each transfer.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_ch.valid <= 1'b0;
			byte_ch.data_byte <= 8'h00;
			byte_ch.track_start <= 1'b0;
			byte_ch.track_last <= 1'b0;
			send_gap = 0;
		end else begin
			if (byte_ch.valid && byte_ch.ready) begin
				predict_track_byte(queued_bytes.pop_front());
				send_gap = pick_idle();
			end
			if (send_gap > 0) begin
				send_gap--;
				byte_ch.valid <= 1'b0;
			end else if (queued_bytes.size() > 0) begin
				byte_ch.valid <= 1'b1;
				byte_ch.data_byte <= queued_bytes[0].data;
				byte_ch.track_start <= queued_bytes[0].start;
				byte_ch.track_last <= queued_bytes[0].last;
			end else begin
				byte_ch.valid <= 1'b0;
			end
		end
	end

	function automatic string fmt_event(input midi_event_t ev);
		return $sformatf({"kind=%0d status=%02h d1=%02h d2=%02h chan=%05h tick=%0d",
			" tempo=%06h notes=%0d last=%0b"},
			ev.kind, ev.status, ev.first_data, ev.second_data, ev.track_channel, ev.tick,
			ev.tempo, ev.notes, ev.last);
	endfunction

	// ------------------------------------------------------------------
	// Event monitor. Each completed transfer is matched against the oldest
	// owed event; after a transfer the sink may stall for a while.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			event_ch.ready <= 1'b0;
			recv_stall = 0;
		end else begin
			if (event_ch.valid && event_ch.ready) begin
				seen_event.kind = kind_t'(event_ch.kind);
				seen_event.status = event_ch.status_out;
				seen_event.first_data = event_ch.first_data;
				seen_event.second_data = event_ch.second_data;
				seen_event.track_channel = event_ch.track_channel;
				seen_event.tick = event_ch.event_tick;
				seen_event.tempo = event_ch.tempo_value;
				seen_event.notes = event_ch.notes_seen;
				seen_event.last = event_ch.last_of_run;
				if (pending_events.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT) begin
						$display("unexpected event: %s", fmt_event(seen_event));
					end
				end else begin
					due_event = pending_events.pop_front();
					if (seen_event !== due_event) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_LIMIT) begin
							$display("event mismatch: expected %s", fmt_event(due_event));
							$display("                actual   %s", fmt_event(seen_event));
						end
					end
				end
				recv_stall = pick_idle();
			end
			if (recv_stall > 0) begin
				recv_stall--;
				event_ch.ready <= 1'b0;
			end else begin
				event_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog: a run that hangs or loses events ends here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Test sequence.
	// ------------------------------------------------------------------
	initial begin
		int random_items;
		int chunk_items;
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_wdata = 16'h0000;
		byte_ch.valid = 1'b0;
		byte_ch.data_byte = 8'h00;
		byte_ch.track_start = 1'b0;
		byte_ch.track_last = 1'b0;
		event_ch.ready = 1'b0;
		steady = 1'b0;
		gen_status = 8'h00;
		cur_track_index = 16'h0000;
		clear_track_state();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Highest track index, so the track/channel field is all ones for
		// channel 15. The track covers a full-scale note-on whose velocity has
		// bit 7 set, a running-status note-on with velocity 0x80 that still
		// counts as a note-on, a zero velocity turned into a note-off, an
		// overlong delta, an undefined system status that drops running
		// status, a data byte read as a delta, end of track, and a byte after
		// end of track that must be ignored.
		write_track_index(16'hFFFF);
		track_buf = '{8'h00, 8'h9F, 8'h7F, 8'hFF,
			8'h00, 8'h40, 8'h80,
			8'h00, 8'h40, 8'h00,
			8'hFF, 8'hFF, 8'hFF, 8'h7F,
			ST_UNDEF_LAST, 8'h05, 8'h22,
			ST_META, META_EOT, 8'h00,
			8'h90};
		flush_track(1'b1, 1'b1);
		wait_drained(LATENCY_PAD);

		// Track index zero: a real note-off, a tempo change, and a track cut
		// off right after a status byte, which yields a truncated marker.
		write_track_index(16'h0000);
		track_buf = '{8'h00, 8'h80, 8'h00, 8'h00,
			8'h00, ST_META, META_TEMPO, 8'h03, 8'h0F, 8'h42, 8'h40,
			8'h00, 8'hB1};
		flush_track(1'b1, 1'b1);
		wait_drained(LATENCY_PAD);

		// Random tracks in chunks. Between chunks the sender holds off until
		// every owed event is back, and the track index is rewritten.
		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			steady = ($urandom_range(0, 3) == 0);
			chunk_items = 0;
			while (chunk_items < CHUNK_ITEMS && random_items + chunk_items < RANDOM_ITEMS)
				chunk_items += build_random_track();
			random_items += chunk_items;
			wait_drained(LATENCY_PAD);
			case ($urandom_range(0, 3))
				0:       write_track_index(16'h0000);
				1:       write_track_index(16'hFFFF);
				default: write_track_index(16'($urandom_range(0, 65535)));
			endcase
		end

		wait_drained(END_PAD);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
